>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Shared constants, opcodes and job word helpers.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int COORD_BITS_DEFAULT = 10;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // A job word carries the done flag, the centre and the octant point.
  function automatic int job_bits(input int coord_bits);
    return 4 * coord_bits + 1;
  endfunction

endpackage

>>> rtl/midpoint_circle_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer core
// Turns start and step items into the eight mirrored pixels of each point.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): opcode OP_START loads a centre and a
// radius and emits the pixels of the point (0, radius); OP_STEP advances the
// octant point by one and emits its pixels. A step with no circle running is
// taken and gives no pixels. Output channel (out_valid / out_stall): one pixel
// per transfer, eight per emitting item, the eighth marked by last_of_step;
// circle_done is set on all eight pixels of the item that ends the octant.
// The first pixel of an item passes a queue entry, the back job register and
// the pixel register. Throughput: one pixel per cycle while out_stall is low,
// set by the single-pixel output register of the back part. A two-entry job
// queue lets the front take up to two further items while pixels drain.
// A stalled receiver holds the current pixel; the queue then fills and
// in_stall rises. Reset empties the queue and leaves no circle running.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_core #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [COORD_BITS-2:0]        radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         last_of_step,
  output logic                         circle_done
);

  localparam int JOB_W = mcr_pkg::job_bits(COORD_BITS);

  logic             push_valid;
  logic             push_stall;
  logic [JOB_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_stall;
  logic [JOB_W-1:0] pop_data;

  mcr_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .job_valid (push_valid),
    .job_stall (push_stall),
    .job_data  (push_data)
  );

  mcr_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_data   (pop_data)
  );

  mcr_back #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (pop_valid),
    .job_stall    (pop_stall),
    .job_data     (pop_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule

>>> rtl/mcr_fifo.sv
// ----------------------------------------------------------------------------
// Job queue
// Two-entry register queue between the front and back parts.
// ----------------------------------------------------------------------------
module mcr_fifo #(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_stall,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_stall,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push_fire;
  logic             pop_fire;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign push_fire  = push_valid && !push_stall;
  assign pop_fire   = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push_fire, pop_fire})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_data;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_fifo_count_range, count > 2'd2, "job queue count out of range")

endmodule

>>> rtl/mcr_front.sv
// ----------------------------------------------------------------------------
// Front part
// Accepts start and step items, advances the midpoint state and queues jobs.
// ----------------------------------------------------------------------------
module mcr_front #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEFAULT,
  parameter int JOB_W      = mcr_pkg::job_bits(COORD_BITS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-2:0] radius,
  output logic                  job_valid,
  input  logic                  job_stall,
  output logic [JOB_W-1:0]      job_data
);

  localparam int W  = COORD_BITS;
  localparam int DW = COORD_BITS + 2;

  logic [W-1:0]  center_col;
  logic [W-1:0]  center_row;
  logic [W-1:0]  offset_a;
  logic [W-1:0]  offset_b;
  logic [DW-1:0] decision;
  logic          active;

  logic [W-1:0]  center_col_next;
  logic [W-1:0]  center_row_next;
  logic [W-1:0]  offset_a_next;
  logic [W-1:0]  offset_b_next;
  logic [DW-1:0] decision_next;
  logic          done_next;

  logic          accept;
  logic          is_start;
  logic          update;
  logic [W:0]    x_inc;
  logic [W-1:0]  y_dec;
  logic          dec_pos;
  logic [DW-1:0] diff;

  assign accept   = in_valid && !in_stall;
  assign is_start = (mcr_pkg::opcode_t'(opcode) == mcr_pkg::OP_START);
  assign update   = accept && (is_start || active);
  assign in_stall = job_stall;

  assign x_inc   = {1'b0, offset_a} + {{W{1'b0}}, 1'b1};
  assign y_dec   = offset_b - {{(W-1){1'b0}}, 1'b1};
  assign dec_pos = !decision[DW-1] && (decision != '0);
  assign diff    = {1'b0, x_inc} - {2'b00, y_dec};

  always_comb begin
    if (is_start) begin
      center_col_next = center_x;
      center_row_next = center_y;
      offset_a_next   = '0;
      offset_b_next   = {1'b0, radius};
      decision_next   = {{(DW-1){1'b0}}, 1'b1} - {3'b000, radius};
    end else begin
      center_col_next = center_col;
      center_row_next = center_row;
      offset_a_next   = x_inc[W-1:0];
      if (dec_pos) begin
        // The octant point moves inwards: y drops and the update uses x - y.
        offset_b_next = y_dec;
        decision_next = decision + {diff[DW-2:0], 1'b0} + {{(DW-1){1'b0}}, 1'b1};
      end else begin
        offset_b_next = offset_b;
        decision_next = decision + {x_inc, 1'b0} + {{(DW-1){1'b0}}, 1'b1};
      end
    end
    done_next = (offset_a_next >= offset_b_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= '0;
      center_row <= '0;
      offset_a   <= '0;
      offset_b   <= '0;
      decision   <= '0;
      active     <= 1'b0;
    end else if (update) begin
      center_col <= center_col_next;
      center_row <= center_row_next;
      offset_a   <= offset_a_next;
      offset_b   <= offset_b_next;
      decision   <= decision_next;
      active     <= !done_next;
    end
  end

  // A step while idle is taken and dropped without a job.
  assign job_valid = in_valid && (is_start || active);
  assign job_data  = {done_next, center_col_next, center_row_next,
                      offset_a_next, offset_b_next};

`include "assert_macros.svh"

  `ASSERT_CLK(a_active_inside_octant, active |-> (offset_a < offset_b),
              "active circle has left its octant")

endmodule

>>> rtl/mcr_back.sv
// ----------------------------------------------------------------------------
// Back part
// Expands each queued job into eight mirrored pixels, one per unstalled cycle.
// ----------------------------------------------------------------------------
module mcr_back #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEFAULT,
  parameter int JOB_W      = mcr_pkg::job_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  output logic                         job_stall,
  input  logic [JOB_W-1:0]             job_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         last_of_step,
  output logic                         circle_done
);

  localparam int W  = COORD_BITS;
  localparam int DW = COORD_BITS + 2;

  logic [JOB_W-1:0] job;
  logic             busy;
  logic [2:0]       index;

  logic             job_done;
  logic [W-1:0]     job_cx;
  logic [W-1:0]     job_cy;
  logic [W-1:0]     job_x;
  logic [W-1:0]     job_y;

  logic             out_free;
  logic             produce;
  logic             take_job;
  logic [W-1:0]     off_a;
  logic [W-1:0]     off_b;
  logic [DW-1:0]    px;
  logic [DW-1:0]    py;

  assign {job_done, job_cx, job_cy, job_x, job_y} = job;

  assign out_free  = !out_valid || !out_stall;
  assign produce   = busy && out_free;
  assign take_job  = !busy || (produce && (index == 3'd7));
  assign job_stall = !take_job;

  // The upper half of the sequence swaps x and y; the low bits pick signs.
  always_comb begin
    off_a = index[2] ? job_y : job_x;
    off_b = index[2] ? job_x : job_y;
    px = index[1] ? ({2'b00, job_cx} - {2'b00, off_a}) : ({2'b00, job_cx} + {2'b00, off_a});
    py = index[0] ? ({2'b00, job_cy} - {2'b00, off_b}) : ({2'b00, job_cy} + {2'b00, off_b});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      index     <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= produce;
      end
      if (job_valid && take_job) begin
        busy  <= 1'b1;
        index <= 3'd0;
      end else if (produce) begin
        index <= index + 3'd1;
        if (index == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && take_job) begin
      job <= job_data;
    end
    if (produce) begin
      pixel_x      <= px;
      pixel_y      <= py;
      last_of_step <= (index == 3'd7);
      circle_done  <= job_done;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_step_pixels_contiguous,
              (out_valid && !out_stall && !last_of_step) |=> out_valid,
              "pixels of one step did not follow back to back")
  `ASSERT_CLK(a_done_steady_in_step,
              (out_valid && !out_stall && !last_of_step) |=> (circle_done == $past(circle_done)),
              "circle_done changed within one step")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer core testbench
// Sends a short table of directed start and step items, then random circles
// with random idle gaps on the input and a varying stall pattern on the
// output. Every pixel is checked against a behavioural octant tracker, or
// against the axis pixels of a start where these are plain to see.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CB = mcr_pkg::COORD_BITS_DEFAULT;
  localparam int EMITTING_TARGET = 500;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_AXES
  } row_kind_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_HOLD
  } stall_mode_t;

  typedef struct packed {
    mcr_pkg::opcode_t op;
    logic [CB-1:0]    cx;
    logic [CB-1:0]    cy;
    logic [CB-2:0]    r;
    row_kind_t        kind;
  } stim_row_t;

  typedef struct packed {
    logic signed [CB+1:0] px;
    logic signed [CB+1:0] py;
    logic                 last;
    logic                 done;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = mcr_pkg::OP_START;
  logic [CB-1:0]         center_x = '0;
  logic [CB-1:0]         center_y = '0;
  logic [CB-2:0]         radius = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [CB+1:0]  pixel_x;
  logic signed [CB+1:0]  pixel_y;
  logic                  last_of_step;
  logic                  circle_done;

  midpoint_circle_rasterizer_core #(.COORD_BITS(CB)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Octant tracker state, a copy of what the core should hold.
  logic [CB-1:0]        ctr_col = '0;
  logic [CB-1:0]        ctr_row = '0;
  logic [CB-1:0]        oct_x = '0;
  logic [CB-1:0]        oct_y = '0;
  logic signed [CB+1:0] decision_q = '0;
  logic                 circle_on = 1'b0;
  pixel_t               plot_buf [8];

  pixel_t pixels_due [$];
  pixel_t due_pixel;
  int     fail_count = 0;
  int     emitting_items = 0;
  int     burst_left = 0;

  // Advances the tracker by one item and leaves its pixels in plot_buf.
  function automatic int plot_item(input mcr_pkg::opcode_t op, input logic [CB-1:0] cx,
                                   input logic [CB-1:0] cy, input logic [CB-2:0] r);
    int   p, x, y, a, b, sa, sb, px, py;
    logic ended;
    if (op == mcr_pkg::OP_START) begin
      ctr_col = cx;
      ctr_row = cy;
      oct_x = '0;
      oct_y = {1'b0, r};
      p = 1 - int'(r);
      decision_q = p[CB+1:0];
    end else begin
      if (!circle_on) return 0;
      p = decision_q;
      x = int'(oct_x) + 1;
      y = int'(oct_y);
      if (p <= 0) begin
        p += 2 * x + 1;
      end else begin
        y -= 1;
        p += 2 * (x - y) + 1;
      end
      oct_x = x[CB-1:0];
      oct_y = y[CB-1:0];
      decision_q = p[CB+1:0];
    end
    ended = oct_x >= oct_y;
    circle_on = !ended;
    // The first four pixels mirror (x, y), the last four the swapped point.
    for (int k = 0; k < 8; k++) begin
      a  = (k < 4) ? int'(oct_x) : int'(oct_y);
      b  = (k < 4) ? int'(oct_y) : int'(oct_x);
      sa = (k & 2) ? -1 : 1;
      sb = (k & 1) ? -1 : 1;
      px = int'(ctr_col) + sa * a;
      py = int'(ctr_row) + sb * b;
      plot_buf[k].px = px[CB+1:0];
      plot_buf[k].py = py[CB+1:0];
      plot_buf[k].last = (k == 7);
      plot_buf[k].done = ended;
    end
    return 8;
  endfunction

  task automatic send_item(input mcr_pkg::opcode_t op, input logic [CB-1:0] cx,
                           input logic [CB-1:0] cy, input logic [CB-2:0] r,
                           input row_kind_t kind);
    int     n, gap, px, py;
    pixel_t axis_pixel;
    @(negedge clk);
    opcode   = op;
    center_x = cx;
    center_y = cy;
    radius   = r;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = plot_item(op, cx, cy, r);
    if (n > 0) emitting_items++;
    case (kind)
      ROW_PREDICT: begin
        for (int k = 0; k < n; k++) pixels_due.push_back(plot_buf[k]);
      end
      ROW_QUIET: begin
        // A step with no circle running must give no pixels at all.
      end
      ROW_AXES: begin
        // A start plots the centre offset by the radius along each axis.
        for (int k = 0; k < 8; k++) begin
          px = (k < 4) ? int'(cx) : ((k < 6) ? int'(cx) + int'(r) : int'(cx) - int'(r));
          py = (k < 4) ? ((k & 1) ? int'(cy) - int'(r) : int'(cy) + int'(r)) : int'(cy);
          axis_pixel.px = px[CB+1:0];
          axis_pixel.py = py[CB+1:0];
          axis_pixel.last = (k == 7);
          axis_pixel.done = (r == 0);
          pixels_due.push_back(axis_pixel);
        end
      end
      default: ;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        center_x = CB'($urandom);
        center_y = CB'($urandom);
        radius   = (CB-1)'($urandom);
        opcode   = 1'($urandom_range(0, 1));
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Receiver stalls in runs of a randomly chosen character.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run = 0;

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run = (stall_mode == STALL_HOLD) ? $urandom_range(1, 12) : $urandom_range(8, 64);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 4) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default:     out_stall = 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected pixel x=%0d y=%0d last=%b done=%b",
                 $time, pixel_x, pixel_y, last_of_step, circle_done);
      end else begin
        due_pixel = pixels_due.pop_front();
        if (due_pixel.px !== pixel_x || due_pixel.py !== pixel_y ||
            due_pixel.last !== last_of_step || due_pixel.done !== circle_done) begin
          fail_count++;
          $display("%0t: expected x=%0d y=%0d last=%b done=%b, got x=%0d y=%0d last=%b done=%b",
                   $time, due_pixel.px, due_pixel.py, due_pixel.last, due_pixel.done,
                   pixel_x, pixel_y, last_of_step, circle_done);
        end
      end
    end
  end

  stim_row_t plan [0:23] = '{
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_QUIET},
    '{mcr_pkg::OP_START, 10'd0,    10'd0,    9'd0,   ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd1023, 10'd1023, 9'd511, ROW_QUIET},
    '{mcr_pkg::OP_START, 10'd1023, 10'd1023, 9'd511, ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT},
    '{mcr_pkg::OP_STEP,  10'd1023, 10'd1023, 9'd511, ROW_PREDICT},
    '{mcr_pkg::OP_START, 10'd0,    10'd0,    9'd511, ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT},
    '{mcr_pkg::OP_START, 10'd1023, 10'd0,    9'd1,   ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_QUIET},
    '{mcr_pkg::OP_START, 10'd0,    10'd1023, 9'd2,   ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT},
    '{mcr_pkg::OP_START, 10'd512,  10'd512,  9'd3,   ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_QUIET},
    '{mcr_pkg::OP_START, 10'd341,  10'd682,  9'd341, ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT},
    '{mcr_pkg::OP_START, 10'd682,  10'd341,  9'd170, ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd1023, 10'd1023, 9'd511, ROW_PREDICT},
    '{mcr_pkg::OP_START, 10'd0,    10'd1023, 9'd256, ROW_AXES},
    '{mcr_pkg::OP_STEP,  10'd0,    10'd0,    9'd0,   ROW_PREDICT}
  };

  initial begin
    int      pick, step_limit;
    logic [CB-2:0] r;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) send_item(plan[i].op, plan[i].cx, plan[i].cy, plan[i].r, plan[i].kind);

    while (emitting_items < EMITTING_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        // Loose item with a random opcode and random fields.
        send_item(mcr_pkg::opcode_t'($urandom_range(0, 1)), CB'($urandom), CB'($urandom),
                  (CB-1)'($urandom), ROW_PREDICT);
      end else begin
        // Mostly small circles so that many run to the end of the octant.
        pick = $urandom_range(0, 99);
        if (pick < 60)      r = (CB-1)'($urandom_range(0, 16));
        else if (pick < 90) r = (CB-1)'($urandom_range(17, 100));
        else if (pick < 97) r = (CB-1)'($urandom_range(101, 300));
        else                r = (CB-1)'($urandom_range(301, 511));
        send_item(mcr_pkg::OP_START, CB'($urandom), CB'($urandom), r, ROW_PREDICT);
        step_limit = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : 1 << 20;
        while (circle_on && step_limit > 0) begin
          send_item(mcr_pkg::OP_STEP, CB'($urandom), CB'($urandom), (CB-1)'($urandom),
                    ROW_PREDICT);
          step_limit--;
        end
        if ($urandom_range(0, 2) == 0)
          send_item(mcr_pkg::OP_STEP, CB'($urandom), CB'($urandom), (CB-1)'($urandom),
                    ROW_PREDICT);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS midpoint_circle_rasterizer_core");
    end else begin
      $display("FAIL midpoint_circle_rasterizer_core");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL midpoint_circle_rasterizer_core");
    $finish;
  end

endmodule
